/* hw/rtl/accel_step_detector_core_defines.svh */
// assertion macros shared by the step detector rtl
`ifndef ACCEL_STEP_DETECTOR_CORE_DEFINES_SVH
`define ACCEL_STEP_DETECTOR_CORE_DEFINES_SVH

// condition that must hold at every clock edge outside reset
`define ASD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/asd_pkg.sv */
package asd_pkg;

    // field widths
    localparam int ACCEL_W = 16;
    localparam int MAG_W   = ACCEL_W + 1;
    localparam int DEV_W   = 22;
    localparam int COUNT_W = 16;
    localparam int SENS_W  = 8;

    // deviation sum saturation value
    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    // register reset and default parameter values
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(10);
    localparam int RING_DEPTH_DEF  = 10;
    localparam int WINDOW_LAST_DEF = 20;

    // item operation codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // sample channel payload
    typedef struct packed {
        t_op                       op;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } t_smp;

    // result channel payload
    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic               step_added;
    } t_res;

endpackage

/* hw/rtl/asd_smp_if.sv */
interface asd_smp_if;

    logic         valid;
    logic         ready;
    asd_pkg::t_smp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* hw/rtl/asd_res_if.sv */
interface asd_res_if;

    logic         valid;
    logic         ready;
    asd_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* hw/rtl/accel_step_detector_core.sv */
// Step detector for a three-axis accelerometer. Each sample transaction carries signed Q7.8
// x/y/z accelerations; the block forms the L1 magnitude, compares it with the mean of a ring of
// RING_DEPTH smoothed values and accumulates the absolute difference over a window of
// WINDOW_LAST+1 samples. When a window closes with a deviation sum above sensitivity*256 the
// 16-bit step count increments (wrapping) and step_added is set; a clear transaction zeroes
// the count. Every transaction gives exactly one result. A transaction is held in the input
// register while the datapath works on it, and its result is loaded into the result register
// when the result register is free or being taken; a new transaction is taken every cycle
// while results are taken. The rate is set by the ring-sum loop through its combinational
// reciprocal multiply for the mean, then the ring update. The ring lives in a memory with a
// registered read that is prefetched one entry ahead, with per-entry valid bits cleared by reset,
// so no clearing pass is needed. Sensitivity must be written only while idle (not enforced).
module accel_step_detector_core #(
    parameter int RING_DEPTH  = asd_pkg::RING_DEPTH_DEF,
    parameter int WINDOW_LAST = asd_pkg::WINDOW_LAST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [asd_pkg::SENS_W-1:0]  i_cfg_wdata,
    asd_smp_if.sink                     i_smp,
    asd_res_if.source                   o_res
);

    `include "accel_step_detector_core_defines.svh"

    localparam int MAG_W   = asd_pkg::MAG_W;
    localparam int DEV_W   = asd_pkg::DEV_W;
    localparam int COUNT_W = asd_pkg::COUNT_W;
    localparam int SENS_W  = asd_pkg::SENS_W;
    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int SUM_W   = MAG_W + IDX_W;
    localparam int WIN_W   = $clog2(WINDOW_LAST + 1);
    // exact reciprocal for the mean: floor(x * RECIP / 2^SHIFT) == x / RING_DEPTH
    localparam int SHIFT   = SUM_W + IDX_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(RING_DEPTH) - 64'd1) / longint'(RING_DEPTH);

    // absolute value of a Q7.8 sample, most negative maps to 32768
    function automatic logic [MAG_W-1:0] abs_accel(logic [asd_pkg::ACCEL_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, v};
        if (v[asd_pkg::ACCEL_W-1]) begin
            return (MAG_W'(1) << asd_pkg::ACCEL_W) - ext;
        end
        return ext;
    endfunction

    // configuration register
    logic [SENS_W-1:0] r_sens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= asd_pkg::SENS_RESET;
        end else if (i_cfg_we) begin
            r_sens <= i_cfg_wdata;
        end
    end

    // input register
    logic          r_in_vld;
    asd_pkg::t_smp r_in;
    logic          fire;

    assign fire        = r_in_vld && (!o_res.valid || o_res.ready);
    assign i_smp.ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_in <= i_smp.data;
        end
    end

    // detector state
    logic [SUM_W-1:0]   r_ring_sum;
    logic [IDX_W-1:0]   r_ring_idx;
    logic [WIN_W-1:0]   r_win_cnt;
    logic [DEV_W-1:0]   r_dev_sum;
    logic [COUNT_W-1:0] r_step_cnt;
    logic [MAG_W-1:0]   r_ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [MAG_W-1:0]   r_old_raw;
    logic               r_old_vld;

    // datapath
    logic               is_sample;
    logic [MAG_W-1:0]   mag;
    logic [PROD_W-1:0]  mean_prod;
    logic [MAG_W-1:0]   mean;
    logic [MAG_W:0]     avg_sum;
    logic [MAG_W-1:0]   avg;
    logic [MAG_W-1:0]   dev;
    logic [MAG_W-1:0]   old_val;
    logic [IDX_W-1:0]   idx_next;
    logic [DEV_W:0]     dev_acc;
    logic [DEV_W-1:0]   dev_sat;
    logic               win_close;
    logic               step_hit;
    logic [SUM_W-1:0]   n_ring_sum;
    logic [WIN_W-1:0]   n_win_cnt;
    logic [DEV_W-1:0]   n_dev_sum;
    logic [COUNT_W-1:0] n_step_cnt;
    logic               n_added;

    always_comb begin
        is_sample = (r_in.op == asd_pkg::OP_SAMPLE);
        mag       = abs_accel(r_in.accel_x) + abs_accel(r_in.accel_y)
                  + abs_accel(r_in.accel_z);
        mean_prod = PROD_W'(r_ring_sum) * PROD_W'(RECIP_W'(RECIP));
        mean      = mean_prod[SHIFT +: MAG_W];
        avg_sum   = {1'b0, mag} + {1'b0, mean};
        avg       = avg_sum[MAG_W:1];
        dev       = (mag >= mean) ? (mag - mean) : (mean - mag);
        old_val   = r_old_vld ? r_old_raw : '0;
        idx_next  = (r_ring_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : r_ring_idx + 1'b1;

        // deviation accumulate with saturation
        dev_acc   = {1'b0, r_dev_sum} + (DEV_W + 1)'(dev);
        dev_sat   = dev_acc[DEV_W] ? asd_pkg::DEV_MAX : dev_acc[DEV_W-1:0];

        win_close = (r_win_cnt >= WIN_W'(WINDOW_LAST));
        step_hit  = dev_sat > DEV_W'({r_sens, 8'h00});

        n_ring_sum = r_ring_sum - SUM_W'(old_val) + SUM_W'(avg);
        n_win_cnt  = r_win_cnt;
        n_dev_sum  = r_dev_sum;
        n_step_cnt = r_step_cnt;
        n_added    = 1'b0;
        if (!is_sample) begin
            n_ring_sum = r_ring_sum;
            n_step_cnt = '0;
        end else if (win_close) begin
            n_win_cnt = '0;
            n_dev_sum = '0;
            if (step_hit) begin
                n_step_cnt = r_step_cnt + 1'b1;
                n_added    = 1'b1;
            end
        end else begin
            n_win_cnt = r_win_cnt + 1'b1;
            n_dev_sum = dev_sat;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_sum <= '0;
            r_ring_idx <= '0;
            r_win_cnt  <= '0;
            r_dev_sum  <= '0;
            r_step_cnt <= '0;
            r_ring_vld <= '0;
            r_old_vld  <= 1'b0;
        end else if (fire) begin
            r_ring_sum <= n_ring_sum;
            r_win_cnt  <= n_win_cnt;
            r_dev_sum  <= n_dev_sum;
            r_step_cnt <= n_step_cnt;
            if (is_sample) begin
                r_ring_idx             <= idx_next;
                r_ring_vld[r_ring_idx] <= 1'b1;
                r_old_vld              <= r_ring_vld[idx_next];
            end
        end
    end

    // ring memory, read one entry ahead of the write
    always_ff @(posedge i_clk) begin
        if (fire && is_sample) begin
            r_ring_mem[r_ring_idx] <= avg;
            r_old_raw              <= r_ring_mem[idx_next];
        end
    end

    // result register
    logic          r_out_vld;
    asd_pkg::t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.step_count <= n_step_cnt;
            r_out.step_added <= n_added;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // checks
    `ASD_ASSERT_ALWAYS(a_ring_idx_range, r_ring_idx <= IDX_W'(RING_DEPTH - 1), "ring index out of range")
    `ASD_ASSERT_ALWAYS(a_win_cnt_range, r_win_cnt <= WIN_W'(WINDOW_LAST), "window counter out of range")
    `ASD_ASSERT_NEXT(a_step_inc, fire && n_added, r_step_cnt == COUNT_W'($past(r_step_cnt) + 1'b1), "step count did not advance by one")
    `ASD_ASSERT_NEXT(a_win_restart, fire && is_sample && win_close, r_dev_sum == '0 && r_win_cnt == '0, "window did not restart")
    `ASD_ASSERT_NEXT(a_in_hold, r_in_vld && !fire, r_in_vld, "buffered transaction dropped")

endmodule
